### rtl/core/assert_macros.svh
// assertion macros shared by the rtl, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

### rtl/core/rru_pkg.sv
// shared constants and types for the register rename unit
package rru_pkg;

   localparam int NUM_ARCH_REGS   = 16;
   localparam int NUM_RENAME_REGS = 32;
   localparam int DATA_WIDTH      = 8;

   localparam int ARCH_W = $clog2(NUM_ARCH_REGS);
   localparam int TAG_W  = $clog2(NUM_RENAME_REGS);

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_ALLOC  = 3'd1,
      OP_WB     = 3'd2,
      OP_RETIRE = 3'd3,
      OP_INIT   = 3'd4
   } op_type;

   // one rename register entry as held in memory
   typedef struct packed {
      logic [ARCH_W-1:0]     owner;
      logic [DATA_WIDTH-1:0] value;
   } rename_word_type;

   // result of the free-entry search
   typedef struct packed {
      logic             found;
      logic [TAG_W-1:0] idx;
   } free_type;

endpackage

### rtl/core/rru_ram.sv
// generic single-port-write, single-port-read ram with registered read
module rru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### rtl/core/rru_free_enc.sv
// priority encoder picking the lowest free rename register
module rru_free_enc (
   input  logic [rru_pkg::NUM_RENAME_REGS-1:0] in_use,
   output rru_pkg::free_type                   free
);

   always_comb begin
      free.found = 1'b0;
      free.idx   = '0;
      // scan from the top so the lowest free entry wins
      for (int i = rru_pkg::NUM_RENAME_REGS - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            free.found = 1'b1;
            free.idx   = rru_pkg::TAG_W'(i);
         end
      end
   end

endmodule

### rtl/core/register_rename_unit_core.sv
// top level of the register rename unit
//
// register rename unit: 16 architectural and 32 rename registers of 8-bit data.
// each request word carries one operation: read source, allocate destination,
// writeback, retire or init of an architectural register; every request gives
// exactly one response word. rename values and owners live in one synchronous
// ram (owner and value packed per entry), architectural values in a second;
// pending flags, latest tags and the valid and in-use bits of the rename
// registers sit in flip-flops so reset clears them at once. an architectural
// value that was never written reads as zero through a per-register written
// bit. an item first reads both rams, then updates the state and writes back,
// and a new request is taken only after the previous one has left its update step. the
// response sits in an output register, so the next request is accepted while
// the previous response still waits; a request only holds in its update step
// when that register is still full and stalled. there is no clearing pass
// after reset.
`include "assert_macros.svh"

module register_rename_unit_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_type,
   input  logic [rru_pkg::ARCH_W-1:0]     req_arch_reg,
   input  logic [rru_pkg::TAG_W-1:0]      req_rename_tag,
   input  logic [rru_pkg::DATA_WIDTH-1:0] req_value_in,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ready_res,
   output logic [rru_pkg::DATA_WIDTH-1:0] rsp_value_out,
   output logic [rru_pkg::TAG_W-1:0]      rsp_tag_out,
   output logic                           rsp_full_res
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   localparam int NA = rru_pkg::NUM_ARCH_REGS;
   localparam int NR = rru_pkg::NUM_RENAME_REGS;
   localparam int AW = rru_pkg::ARCH_W;
   localparam int TW = rru_pkg::TAG_W;
   localparam int DW = rru_pkg::DATA_WIDTH;
   localparam int RWW = $bits(rru_pkg::rename_word_type);

   // sequencer and captured request
   state_type        state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [AW-1:0]    ar_ff, ar_in;
   logic [TW-1:0]    rt_ff, rt_in;
   logic [DW-1:0]    val_ff, val_in;

   // flip-flop state
   logic [NA-1:0]    arch_pending_ff, arch_pending_in;
   logic [NA-1:0]    arch_written_ff, arch_written_in;
   logic [TW-1:0]    arch_latest_tag_ff [NA];
   logic [TW-1:0]    arch_latest_tag_in [NA];
   logic [NR-1:0]    rename_valid_ff, rename_valid_in;
   logic [NR-1:0]    rename_in_use_ff, rename_in_use_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ready_ff, rsp_ready_in;
   logic [DW-1:0]    rsp_value_ff, rsp_value_in;
   logic [TW-1:0]    rsp_tag_ff, rsp_tag_in;
   logic             rsp_full_ff, rsp_full_in;

   // ram ports
   logic                      ren_wr_en, ren_rd_en;
   logic [TW-1:0]             ren_wr_addr, ren_rd_addr;
   rru_pkg::rename_word_type  ren_wr_word, ren_rd_word;
   logic [RWW-1:0]            ren_rd_bits;
   logic                      arc_wr_en, arc_rd_en;
   logic [AW-1:0]             arc_wr_addr, arc_rd_addr;
   logic [DW-1:0]             arc_wr_data, arc_rd_data;

   rru_pkg::free_type free;

   logic req_ack;
   logic advance;
   logic ar_ok;
   logic rt_ok;
   logic [TW-1:0] pend_tag;
   logic [AW-1:0] owner;

   // rename registers: owner and value per entry
   rru_ram #(
      .WIDTH (RWW),
      .DEPTH (NR)
   ) u_rename_ram (
      .clock   (clock),
      .wr_en   (ren_wr_en),
      .wr_addr (ren_wr_addr),
      .wr_data (ren_wr_word),
      .rd_en   (ren_rd_en),
      .rd_addr (ren_rd_addr),
      .rd_data (ren_rd_bits)
   );

   assign ren_rd_word = rru_pkg::rename_word_type'(ren_rd_bits);

   // architectural register values
   rru_ram #(
      .WIDTH (DW),
      .DEPTH (NA)
   ) u_arch_ram (
      .clock   (clock),
      .wr_en   (arc_wr_en),
      .wr_addr (arc_wr_addr),
      .wr_data (arc_wr_data),
      .rd_en   (arc_rd_en),
      .rd_addr (arc_rd_addr),
      .rd_data (arc_rd_data)
   );

   // lowest free rename register for allocation
   rru_free_enc u_free_enc (
      .in_use (rename_in_use_ff),
      .free   (free)
   );

   // one request in flight; the update step holds while the response is stuck
   assign req_stall = (state_ff != S_IDLE);
   assign req_ack   = req_valid && !req_stall;
   assign advance   = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign ar_ok    = (32'(ar_ff) < NA);
   assign rt_ok    = (32'(rt_ff) < NR);
   assign pend_tag = arch_latest_tag_ff[ar_ff];
   assign owner    = ren_rd_word.owner;

   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      ar_in              = ar_ff;
      rt_in              = rt_ff;
      val_in             = val_ff;
      arch_pending_in    = arch_pending_ff;
      arch_written_in    = arch_written_ff;
      arch_latest_tag_in = arch_latest_tag_ff;
      rename_valid_in    = rename_valid_ff;
      rename_in_use_in   = rename_in_use_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_ready_in       = rsp_ready_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_tag_in         = rsp_tag_ff;
      rsp_full_in        = rsp_full_ff;

      ren_wr_en   = 1'b0;
      ren_wr_addr = rt_ff;
      ren_wr_word = ren_rd_word;
      ren_rd_en   = 1'b0;
      ren_rd_addr = req_rename_tag;
      arc_wr_en   = 1'b0;
      arc_wr_addr = ar_ff;
      arc_wr_data = val_ff;
      arc_rd_en   = 1'b0;
      arc_rd_addr = req_arch_reg;

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ack) begin
               op_in     = req_type;
               ar_in     = req_arch_reg;
               rt_in     = req_rename_tag;
               val_in    = req_value_in;
               ren_rd_en = 1'b1;
               arc_rd_en = 1'b1;
               // a source read looks at the latest rename of its register
               if (req_type == rru_pkg::OP_READ) begin
                  ren_rd_addr = arch_latest_tag_ff[req_arch_reg];
               end
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_ready_in = 1'b0;
               rsp_value_in = '0;
               rsp_tag_in   = '0;
               rsp_full_in  = 1'b0;
               state_in     = S_IDLE;
               case (op_ff)
                  rru_pkg::OP_READ: begin
                     if (ar_ok) begin
                        if (!arch_pending_ff[ar_ff]) begin
                           rsp_ready_in = 1'b1;
                           rsp_value_in = arch_written_ff[ar_ff] ? arc_rd_data : '0;
                        end else if (rename_valid_ff[pend_tag]) begin
                           rsp_ready_in = 1'b1;
                           rsp_value_in = ren_rd_word.value;
                        end else begin
                           rsp_tag_in = pend_tag;
                        end
                     end
                  end
                  rru_pkg::OP_ALLOC: begin
                     if (ar_ok) begin
                        if (free.found) begin
                           rename_in_use_in[free.idx]   = 1'b1;
                           rename_valid_in[free.idx]    = 1'b0;
                           arch_latest_tag_in[ar_ff]    = free.idx;
                           arch_pending_in[ar_ff]       = 1'b1;
                           ren_wr_en                    = 1'b1;
                           ren_wr_addr                  = free.idx;
                           ren_wr_word.owner            = ar_ff;
                           ren_wr_word.value            = '0;
                           rsp_tag_in                   = free.idx;
                        end else begin
                           rsp_full_in = 1'b1;
                        end
                     end
                  end
                  rru_pkg::OP_WB: begin
                     // keep the owner, replace the value
                     if (rt_ok && rename_in_use_ff[rt_ff]) begin
                        ren_wr_en            = 1'b1;
                        ren_wr_word.value    = val_ff;
                        rename_valid_in[rt_ff] = 1'b1;
                     end
                  end
                  rru_pkg::OP_RETIRE: begin
                     if (rt_ok && rename_in_use_ff[rt_ff] && rename_valid_ff[rt_ff]) begin
                        if (32'(owner) < NA) begin
                           arc_wr_en              = 1'b1;
                           arc_wr_addr            = owner;
                           arc_wr_data            = ren_rd_word.value;
                           arch_written_in[owner] = 1'b1;
                           // a stale retire leaves a newer rename pending
                           if (arch_latest_tag_ff[owner] == rt_ff) begin
                              arch_pending_in[owner] = 1'b0;
                           end
                        end
                        rename_in_use_in[rt_ff] = 1'b0;
                        rename_valid_in[rt_ff]  = 1'b0;
                     end
                  end
                  rru_pkg::OP_INIT: begin
                     if (ar_ok) begin
                        arc_wr_en              = 1'b1;
                        arch_written_in[ar_ff] = 1'b1;
                     end
                  end
                  default: begin
                     // unknown operation: all-zero response, no change
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         arch_pending_ff  <= '0;
         arch_written_ff  <= '0;
         rename_valid_ff  <= '0;
         rename_in_use_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < NA; i++) begin
            arch_latest_tag_ff[i] <= '0;
         end
      end else begin
         state_ff           <= state_in;
         arch_pending_ff    <= arch_pending_in;
         arch_written_ff    <= arch_written_in;
         rename_valid_ff    <= rename_valid_in;
         rename_in_use_ff   <= rename_in_use_in;
         rsp_valid_ff       <= rsp_valid_in;
         arch_latest_tag_ff <= arch_latest_tag_in;
      end
      // payload registers
      op_ff        <= op_in;
      ar_ff        <= ar_in;
      rt_ff        <= rt_in;
      val_ff       <= val_in;
      rsp_ready_ff <= rsp_ready_in;
      rsp_value_ff <= rsp_value_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ready_res = rsp_ready_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_tag_out   = rsp_tag_ff;
   assign rsp_full_res  = rsp_full_ff;

   // a rename register holding a value is always allocated
   `ASSERT_ALWAYS(a_valid_in_use,
      (rename_valid_ff & ~rename_in_use_ff) == '0, "valid entry not in use")

   // a pending architectural register points at a live rename register
   `ASSERT_IMPLY(a_pending_live, (state_ff == S_EXEC) && arch_pending_ff[ar_ff],
      rename_in_use_ff[arch_latest_tag_ff[ar_ff]], "pending register tag not in use")

   // a response only appears after the update cycle of a request
   `ASSERT_IMPLY(a_rsp_from_exec, $rose(rsp_valid_ff), $past(state_ff == S_EXEC), "response without request")

endmodule
